/* rtl/olst_pkg.sv */
// Shared types, sizes and helpers for the ordered list engine.
// Depends on nothing; imported by the top level.
package olst_pkg;

   localparam int Capacity = 16;
   localparam int DataW    = 32;
   localparam int IdxW     = $clog2(Capacity);
   localparam int LinkW    = $clog2(Capacity + 1);
   localparam logic [LinkW-1:0] Nil = LinkW'(Capacity);

   typedef enum logic [2:0] {
      OP_INS_FRONT  = 3'd0,
      OP_INS_BEFORE = 3'd1,
      OP_INS_AFTER  = 3'd2,
      OP_INS_END    = 3'd3,
      OP_READ_ALL   = 3'd4,
      OP_DEL_FIRST  = 3'd5,
      OP_DEL_VALUE  = 3'd6,
      OP_DEL_LAST   = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_WALK,
      S_WR_NEW,
      S_WR_PREV,
      S_RESP
   } state_type;

   // Lowest-numbered free slot, or Nil when every slot is taken.
   function automatic logic [LinkW-1:0] first_free(input logic [Capacity-1:0] used);
      logic [LinkW-1:0] slot;
      slot = Nil;
      for (int i = Capacity - 1; i >= 0; i--) begin
         if (!used[i]) begin
            slot = LinkW'(i);
         end
      end
      return slot;
   endfunction

endpackage

/* rtl/olst_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the slot value and slot link stores.
module olst_ram #(
   parameter int Width = 32,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/ordered_list_engine.sv */
// Ordered list engine: a bounded list of signed values kept in linked slots.
// Front insert and delete first act at the head; searches, insert at end and
// delete last walk the list one link per cycle.
// Read all delivers one entry per cycle when the result side keeps up.
// Reset empties the list at once; the slot stores are not cleared.
// Depends on olst_pkg and olst_ram.
module ordered_list_engine
   import olst_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [2:0]              req_op,
   input  logic signed [DataW-1:0] req_value,
   input  logic signed [DataW-1:0] req_key,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [1:0]              rsp_status,
   output logic signed [DataW-1:0] rsp_item,
   output logic                    rsp_last
);

   state_type state_ff, state_in;
   op_type op_ff, op_in;
   logic signed [DataW-1:0] val_ff, val_in, key_ff, key_in;
   logic [LinkW-1:0] cur_ff, cur_in, prev_ff, prev_in, step_ff, step_in;
   logic [LinkW-1:0] new_ff, new_in, lnew_ff, lnew_in, plink_ff, plink_in;
   status_type status_ff, status_in;
   logic [LinkW-1:0] head_ff, head_in, count_ff, count_in;
   logic [Capacity-1:0] used_ff, used_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   status_type rsp_status_ff, rsp_status_in;
   logic signed [DataW-1:0] rsp_item_ff, rsp_item_in;

   logic [IdxW-1:0] rd_addr, link_waddr;
   logic [LinkW-1:0] link_wdata, link_rd, nxt, step_next, free_slot;
   logic [DataW-1:0] val_rd;
   logic val_we, link_we;
   logic can_emit, full, empty, at_end, match, req_ins, op_search, op_tail;
   op_type req_op_t;

   olst_ram #(.Width(DataW), .Depth(Capacity)) u_value_ram (
      .clock (clock),
      .we    (val_we),
      .waddr (new_ff[IdxW-1:0]),
      .wdata (val_ff),
      .raddr (rd_addr),
      .rdata (val_rd)
   );

   olst_ram #(.Width(LinkW), .Depth(Capacity)) u_link_ram (
      .clock (clock),
      .we    (link_we),
      .waddr (link_waddr),
      .wdata (link_wdata),
      .raddr (rd_addr),
      .rdata (link_rd)
   );

   assign req_op_t  = op_type'(req_op);
   assign req_ready = (state_ff == S_IDLE);
   assign can_emit  = !rsp_valid_ff || rsp_ready;
   assign full      = (count_ff == LinkW'(Capacity));
   assign empty     = (count_ff == '0) || (head_ff == Nil);
   assign free_slot = first_free(used_ff);
   assign req_ins   = (req_op_t == OP_INS_FRONT) || (req_op_t == OP_INS_BEFORE) ||
                      (req_op_t == OP_INS_AFTER) || (req_op_t == OP_INS_END);
   assign op_search = (op_ff == OP_INS_BEFORE) || (op_ff == OP_INS_AFTER) ||
                      (op_ff == OP_DEL_VALUE);
   assign op_tail   = (op_ff == OP_INS_END) || (op_ff == OP_DEL_LAST);
   assign nxt       = (link_rd >= Nil) ? Nil : link_rd;
   assign step_next = step_ff + LinkW'(1);
   assign at_end    = (step_next >= count_ff) || (nxt == Nil);
   assign match     = ($signed(val_rd) == ((op_ff == OP_DEL_VALUE) ? val_ff : key_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= Nil;
         count_ff     <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      val_ff        <= val_in;
      key_ff        <= key_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      step_ff       <= step_in;
      new_ff        <= new_in;
      lnew_ff       <= lnew_in;
      plink_ff      <= plink_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_item_ff   <= rsp_item_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      val_in        = val_ff;
      key_in        = key_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      step_in       = step_ff;
      new_in        = new_ff;
      lnew_in       = lnew_ff;
      plink_in      = plink_ff;
      status_in     = status_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      used_in       = used_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_item_in   = rsp_item_ff;
      rsp_last_in   = rsp_last_ff;
      rd_addr       = cur_ff[IdxW-1:0];
      val_we        = 1'b0;
      link_we       = 1'b0;
      link_waddr    = new_ff[IdxW-1:0];
      link_wdata    = lnew_ff;

      unique case (state_ff)
         S_IDLE: begin
            rd_addr = head_ff[IdxW-1:0];
            if (req_valid) begin
               op_in     = req_op_t;
               val_in    = req_value;
               key_in    = req_key;
               cur_in    = head_ff;
               prev_in   = Nil;
               step_in   = '0;
               new_in    = free_slot;
               lnew_in   = head_ff;
               plink_in  = Nil;
               status_in = ST_OK;
               if (req_ins && full) begin
                  status_in = ST_FULL;
                  state_in  = S_RESP;
               end else if ((req_op_t == OP_INS_FRONT) ||
                            ((req_op_t == OP_INS_END) && empty)) begin
                  state_in = S_WR_NEW;
               end else if (empty) begin
                  if ((req_op_t == OP_READ_ALL) || (req_op_t == OP_DEL_FIRST) ||
                      (req_op_t == OP_DEL_LAST)) begin
                     status_in = ST_EMPTY;
                  end else begin
                     status_in = ST_NOT_FOUND;
                  end
                  state_in = S_RESP;
               end else begin
                  state_in = S_WALK;
               end
            end
         end

         S_WALK: begin
            if (op_ff == OP_READ_ALL) begin
               if (can_emit) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_OK;
                  rsp_item_in   = val_rd;
                  rsp_last_in   = at_end;
                  if (at_end) begin
                     state_in = S_IDLE;
                  end else begin
                     cur_in  = nxt;
                     prev_in = cur_ff;
                     step_in = step_next;
                     rd_addr = nxt[IdxW-1:0];
                  end
               end
            end else if ((op_ff == OP_DEL_FIRST) || (op_tail && at_end) ||
                         (op_search && match)) begin
               if (op_ff == OP_INS_BEFORE) begin
                  lnew_in  = cur_ff;
                  plink_in = prev_ff;
                  state_in = S_WR_NEW;
               end else if ((op_ff == OP_INS_AFTER) || (op_ff == OP_INS_END)) begin
                  lnew_in  = nxt;
                  plink_in = cur_ff;
                  state_in = S_WR_NEW;
               end else begin
                  if (prev_ff == Nil) begin
                     head_in = nxt;
                  end else begin
                     link_we    = 1'b1;
                     link_waddr = prev_ff[IdxW-1:0];
                     link_wdata = nxt;
                  end
                  used_in[cur_ff[IdxW-1:0]] = 1'b0;
                  count_in  = count_ff - LinkW'(1);
                  status_in = ST_OK;
                  state_in  = S_RESP;
               end
            end else if (at_end) begin
               status_in = ST_NOT_FOUND;
               state_in  = S_RESP;
            end else begin
               cur_in  = nxt;
               prev_in = cur_ff;
               step_in = step_next;
               rd_addr = nxt[IdxW-1:0];
            end
         end

         S_WR_NEW: begin
            val_we     = 1'b1;
            link_we    = 1'b1;
            link_waddr = new_ff[IdxW-1:0];
            link_wdata = lnew_ff;
            used_in[new_ff[IdxW-1:0]] = 1'b1;
            count_in   = count_ff + LinkW'(1);
            if (plink_ff == Nil) begin
               head_in  = new_ff;
               state_in = S_RESP;
            end else begin
               state_in = S_WR_PREV;
            end
         end

         S_WR_PREV: begin
            link_we    = 1'b1;
            link_waddr = plink_ff[IdxW-1:0];
            link_wdata = new_ff;
            state_in   = S_RESP;
         end

         S_RESP: begin
            if (can_emit) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_item_in   = '0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_item   = rsp_item_ff;
   assign rsp_last   = rsp_last_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LinkW'(Capacity))
      else $error("Entry count exceeds the capacity.");

   a_used_matches_count: assert property (@(posedge clock) disable iff (reset)
      $countones(used_ff) == int'(count_ff))
      else $error("Occupied slot bits disagree with the entry count.");

   a_head_null_iff_empty: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) == (head_ff == Nil))
      else $error("Head pointer and entry count disagree on emptiness.");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != ST_OK)) |-> rsp_last_ff)
      else $error("An error status transfer is not marked last.");
`endif

endmodule
